[rtl/dhalloc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhalloc_pkg: shared types and constants of the double-ended hunk allocator
// Sizes, request and result payloads, codes, controller states and helpers.
// ----------------------------------------------------------------------------
package dhalloc_pkg;

  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned TEMP_DEPTH = 32;
  localparam int unsigned ADDR_BITS  = 26;

  localparam int unsigned OFF_W      = ADDR_BITS;
  localparam int unsigned LVL_W      = ADDR_BITS + 1;
  // Two spare bits hold the sum of both committed levels plus a page growth.
  localparam int unsigned ALU_W      = LVL_W + 2;
  localparam int unsigned PAGE_BITS  = $clog2(PAGE_BYTES);
  localparam int unsigned TEMP_IDX_W = (TEMP_DEPTH > 1) ? $clog2(TEMP_DEPTH) : 1;
  localparam int unsigned TEMP_CNT_W = $clog2(TEMP_DEPTH + 1);

  localparam logic [LVL_W-1:0] HUNK_RESET = LVL_W'(16777216);
  localparam logic [ALU_W-1:0] PAGE_LOW   = ALU_W'(PAGE_BYTES - 1);

  // Places of the saved levels in the mark set.
  localparam int unsigned MK_BOT_PAGES = 0;
  localparam int unsigned MK_BOT_USED  = 1;
  localparam int unsigned MK_TOP_PAGES = 2;
  localparam int unsigned MK_TOP_USED  = 3;
  localparam int unsigned MK_NUM       = 4;

  typedef enum logic [2:0] {
    REQ_ALLOC       = 3'd0,
    REQ_ALLOC_TEMP  = 3'd1,
    REQ_FREE_TEMP   = 3'd2,
    REQ_CLEAR_TEMP  = 3'd3,
    REQ_SWAP        = 3'd4,
    REQ_CLEAR       = 3'd5,
    REQ_SET_MARK    = 3'd6,
    REQ_CLEAR_MARK  = 3'd7
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_ROOM = 2'd1,
    STAT_REFUSED = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PG_NONE     = 2'd0,
    PG_COMMIT   = 2'd1,
    PG_DECOMMIT = 2'd2
  } page_op_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_NEED,
    S_A_DIFF,
    S_A_ROUND,
    S_A_SUM1,
    S_A_SUM2,
    S_A_CHK,
    S_A_NEWPG,
    S_A_BLK,
    S_A_POFF,
    S_F_CMP,
    S_F_FREED,
    S_F_NEWPG,
    S_F_POFF,
    S_T_POFF,
    S_M_BOT,
    S_M_TOP,
    S_M_TOFF,
    S_EMIT0,
    S_EMIT1
  } ctrl_state_e;

  typedef struct packed {
    req_type_e        req_type;
    logic [LVL_W-1:0] req_size;
    logic [OFF_W-1:0] req_offset;
  } req_t;

  typedef struct packed {
    logic [LVL_W-1:0] block_offset;
    status_e          status;
    page_op_e         page_op;
    logic [OFF_W-1:0] page_offset;
    logic [LVL_W-1:0] page_length;
    logic             last_result;
  } res_t;

  typedef struct packed {
    logic idle;
    logic valid;
    res_t res;
  } ctrl_out_t;

  function automatic logic [ALU_W-1:0] lvl_ext(input logic [LVL_W-1:0] lvl);
    return ALU_W'(lvl);
  endfunction

  function automatic logic [ALU_W-1:0] page_floor(input logic [ALU_W-1:0] v);
    return {v[ALU_W-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
  endfunction

  function automatic res_t mk_res(input logic [LVL_W-1:0] blk, input status_e st,
                                  input page_op_e op, input logic [OFF_W-1:0] off,
                                  input logic [LVL_W-1:0] len);
    res_t r;
    r.block_offset = blk;
    r.status       = st;
    r.page_op      = op;
    r.page_offset  = off;
    r.page_length  = len;
    r.last_result  = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/dhalloc_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhalloc_alu: shared add and subtract unit
// One adder serves every level computation; the carry doubles as the
// unsigned borrow, and a saturated form clamps negative differences to zero.
// ----------------------------------------------------------------------------
module dhalloc_alu (
  input  dhalloc_pkg::alu_op_e           op_i,
  input  logic [dhalloc_pkg::ALU_W-1:0]  a_i,
  input  logic [dhalloc_pkg::ALU_W-1:0]  b_i,
  output logic [dhalloc_pkg::ALU_W-1:0]  res_o,
  output logic [dhalloc_pkg::ALU_W-1:0]  res_sat_o,
  output logic                           flag_o
);
  import dhalloc_pkg::*;

  logic [ALU_W:0] wide;

  always_comb begin
    unique case (op_i)
      ALU_ADD: wide = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: wide = {1'b0, a_i} - {1'b0, b_i};
      default: wide = '0;
    endcase
  end

  assign res_o     = wide[ALU_W-1:0];
  assign flag_o    = wide[ALU_W];
  assign res_sat_o = ((op_i == ALU_SUB) && wide[ALU_W]) ? '0 : wide[ALU_W-1:0];

endmodule
`default_nettype wire

[rtl/dhalloc_tstack.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhalloc_tstack: storage for the offsets of live temporary blocks
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dhalloc_tstack (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [dhalloc_pkg::TEMP_IDX_W-1:0]  waddr_i,
  input  logic [dhalloc_pkg::OFF_W-1:0]       wdata_i,
  input  logic [dhalloc_pkg::TEMP_IDX_W-1:0]  raddr_i,
  output logic [dhalloc_pkg::OFF_W-1:0]       rdata_o
);
  import dhalloc_pkg::*;

  logic [OFF_W-1:0] mem_q [TEMP_DEPTH];
  logic [OFF_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/dhalloc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhalloc_ctrl: request sequencer and allocator state
// Holds both stack ends, the marks, the bank flag and the temporary count,
// and steps each request through the shared adder one operation a cycle.
// ----------------------------------------------------------------------------
module dhalloc_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  dhalloc_pkg::req_t              in_data_i,
  input  logic [dhalloc_pkg::LVL_W-1:0]  hunk_i,
  input  logic                           res_ready_i,
  output dhalloc_pkg::ctrl_out_t         ctrl_o
);
  import dhalloc_pkg::*;

  ctrl_state_e state_q, state_d;
  req_t        req_q, req_d;
  logic        sel_top_q, sel_top_d;
  logic        grow_q, grow_d;
  logic        bres_q, bres_d;
  logic        tcond_q, tcond_d;
  logic        two_q, two_d;
  logic        tat_q, tat_d;
  logic [TEMP_CNT_W-1:0] cnt_q, cnt_d, cnt_m1;
  logic [LVL_W-1:0] bot_used_q, bot_used_d, bot_pages_q, bot_pages_d;
  logic [LVL_W-1:0] top_used_q, top_used_d, top_pages_q, top_pages_d;
  logic [LVL_W-1:0] mark_q [MK_NUM];
  logic [LVL_W-1:0] mark_d [MK_NUM];
  logic [ALU_W-1:0] sa_q, sa_d, sb_q, sb_d, sc_q, sc_d;
  res_t res0_q, res0_d, res1_q, res1_d;

  alu_op_e          alu_op;
  logic [ALU_W-1:0] alu_a, alu_b, alu_res, alu_sat;
  logic             alu_flag;

  logic                  mem_we;
  logic [OFF_W-1:0]      mem_rdata;
  logic [LVL_W-1:0]      cur_used, cur_pages;
  logic                  diff_pos;
  logic [ALU_W-1:0]      freed;
  logic                  fin;
  logic [LVL_W-1:0]      fin_blk, fin_pages;
  logic [OFF_W-1:0]      fin_poff;
  res_t                  top_rel;

  dhalloc_alu u_alu (
    .op_i      (alu_op),
    .a_i       (alu_a),
    .b_i       (alu_b),
    .res_o     (alu_res),
    .res_sat_o (alu_sat),
    .flag_o    (alu_flag)
  );

  assign cnt_m1 = cnt_q - TEMP_CNT_W'(1);

  // The read address follows the count, so the latest entry is already read
  // out when a free reaches its compare state.
  dhalloc_tstack u_tstack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[TEMP_IDX_W-1:0]),
    .wdata_i (fin_blk[OFF_W-1:0]),
    .raddr_i (cnt_m1[TEMP_IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  assign cur_used  = sel_top_q ? top_used_q : bot_used_q;
  assign cur_pages = sel_top_q ? top_pages_q : bot_pages_q;
  assign diff_pos  = !alu_flag && (alu_res != '0);
  assign freed     = page_floor(alu_sat);
  assign top_rel   = mk_res('0, STAT_OK, PG_DECOMMIT, alu_sat[OFF_W-1:0], top_pages_q);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    sel_top_d   = sel_top_q;
    grow_d      = grow_q;
    bres_d      = bres_q;
    tcond_d     = tcond_q;
    two_d       = two_q;
    tat_d       = tat_q;
    cnt_d       = cnt_q;
    bot_used_d  = bot_used_q;
    bot_pages_d = bot_pages_q;
    top_used_d  = top_used_q;
    top_pages_d = top_pages_q;
    for (int i = 0; i < MK_NUM; i++) begin
      mark_d[i] = mark_q[i];
    end
    sa_d        = sa_q;
    sb_d        = sb_q;
    sc_d        = sc_q;
    res0_d      = res0_q;
    res1_d      = res1_q;
    alu_op      = ALU_ADD;
    alu_a       = '0;
    alu_b       = '0;
    mem_we      = 1'b0;
    fin         = 1'b0;
    fin_blk     = cur_used;
    fin_pages   = sc_q[LVL_W-1:0];
    fin_poff    = cur_pages[OFF_W-1:0];
    ctrl_o.idle  = (state_q == S_IDLE);
    ctrl_o.valid = 1'b0;
    ctrl_o.res   = res0_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d  = in_data_i;
          two_d  = 1'b0;
          res0_d = mk_res('0, STAT_OK, PG_NONE, '0, '0);
          unique case (in_data_i.req_type)
            REQ_ALLOC: begin
              sel_top_d = !tat_q;
              state_d   = S_A_NEED;
            end
            REQ_ALLOC_TEMP: begin
              if (cnt_q >= TEMP_CNT_W'(TEMP_DEPTH)) begin
                res0_d  = mk_res('0, STAT_FULL, PG_NONE, '0, '0);
                state_d = S_EMIT0;
              end else begin
                sel_top_d = tat_q;
                state_d   = S_A_NEED;
              end
            end
            REQ_FREE_TEMP: begin
              sel_top_d = tat_q;
              if (cnt_q == '0) begin
                res0_d  = mk_res('0, STAT_REFUSED, PG_NONE, '0, '0);
                state_d = S_EMIT0;
              end else begin
                state_d = S_F_CMP;
              end
            end
            REQ_CLEAR_TEMP: begin
              if (tat_q) begin
                state_d = S_T_POFF;
              end else begin
                if (bot_pages_q != '0) begin
                  res0_d = mk_res('0, STAT_OK, PG_DECOMMIT, '0, bot_pages_q);
                end
                bot_used_d  = '0;
                bot_pages_d = '0;
                cnt_d       = '0;
                state_d     = S_EMIT0;
              end
            end
            REQ_SWAP: begin
              tat_d   = !tat_q;
              state_d = S_EMIT0;
            end
            REQ_CLEAR: begin
              state_d = S_T_POFF;
            end
            REQ_SET_MARK: begin
              mark_d[MK_BOT_PAGES] = bot_pages_q;
              mark_d[MK_BOT_USED]  = bot_used_q;
              mark_d[MK_TOP_PAGES] = top_pages_q;
              mark_d[MK_TOP_USED]  = top_used_q;
              state_d = S_EMIT0;
            end
            REQ_CLEAR_MARK: begin
              state_d = S_M_BOT;
            end
            default: state_d = S_EMIT0;
          endcase
        end
      end

      S_A_NEED: begin
        alu_a   = lvl_ext(cur_used);
        alu_b   = lvl_ext(req_q.req_size);
        sa_d    = alu_res;
        state_d = S_A_DIFF;
      end
      S_A_DIFF: begin
        alu_op  = ALU_SUB;
        alu_a   = sa_q;
        alu_b   = lvl_ext(cur_pages);
        grow_d  = diff_pos;
        sb_d    = diff_pos ? alu_res : '0;
        state_d = diff_pos ? S_A_ROUND : S_A_NEWPG;
      end
      S_A_ROUND: begin
        alu_a   = sb_q;
        alu_b   = PAGE_LOW;
        sb_d    = page_floor(alu_res);
        state_d = S_A_SUM1;
      end
      S_A_SUM1: begin
        alu_a   = lvl_ext(bot_pages_q);
        alu_b   = lvl_ext(top_pages_q);
        sc_d    = alu_res;
        state_d = S_A_SUM2;
      end
      S_A_SUM2: begin
        alu_a   = sc_q;
        alu_b   = sb_q;
        sc_d    = alu_res;
        state_d = S_A_CHK;
      end
      S_A_CHK: begin
        // Both committed ends together may not pass the end of the region.
        alu_op = ALU_SUB;
        alu_a  = lvl_ext(hunk_i);
        alu_b  = sc_q;
        if (alu_flag) begin
          res0_d  = mk_res('0, STAT_NO_ROOM, PG_NONE, '0, '0);
          state_d = S_EMIT0;
        end else begin
          state_d = S_A_NEWPG;
        end
      end
      S_A_NEWPG: begin
        alu_a = lvl_ext(cur_pages);
        alu_b = sb_q;
        sc_d  = alu_res;
        if (sel_top_q) begin
          state_d = S_A_BLK;
        end else begin
          fin       = 1'b1;
          fin_pages = alu_res[LVL_W-1:0];
        end
      end
      S_A_BLK: begin
        alu_op = ALU_SUB;
        alu_a  = lvl_ext(hunk_i);
        alu_b  = sa_q;
        if (grow_q) begin
          res0_d.block_offset = alu_sat[LVL_W-1:0];
          state_d = S_A_POFF;
        end else begin
          fin     = 1'b1;
          fin_blk = alu_sat[LVL_W-1:0];
        end
      end
      S_A_POFF: begin
        alu_op   = ALU_SUB;
        alu_a    = lvl_ext(hunk_i);
        alu_b    = sc_q;
        fin      = 1'b1;
        fin_blk  = res0_q.block_offset;
        fin_poff = alu_sat[OFF_W-1:0];
      end

      S_F_CMP: begin
        alu_op = ALU_SUB;
        alu_a  = lvl_ext(cur_used);
        alu_b  = lvl_ext(req_q.req_size);
        sa_d   = alu_sat;
        if (mem_rdata != req_q.req_offset) begin
          res0_d  = mk_res('0, STAT_REFUSED, PG_NONE, '0, '0);
          state_d = S_EMIT0;
        end else begin
          state_d = S_F_FREED;
        end
      end
      S_F_FREED: begin
        // Only whole pages above the new used level are released.
        alu_op = ALU_SUB;
        alu_a  = lvl_ext(cur_pages);
        alu_b  = sa_q;
        sb_d   = freed;
        if (freed == '0) begin
          if (sel_top_q) begin
            top_used_d = sa_q[LVL_W-1:0];
          end else begin
            bot_used_d = sa_q[LVL_W-1:0];
          end
          cnt_d   = cnt_m1;
          state_d = S_EMIT0;
        end else begin
          state_d = S_F_NEWPG;
        end
      end
      S_F_NEWPG: begin
        alu_op = ALU_SUB;
        alu_a  = lvl_ext(cur_pages);
        alu_b  = sb_q;
        sc_d   = alu_res;
        if (sel_top_q) begin
          state_d = S_F_POFF;
        end else begin
          res0_d = mk_res('0, STAT_OK, PG_DECOMMIT, alu_res[OFF_W-1:0],
                          sb_q[LVL_W-1:0]);
          bot_used_d  = sa_q[LVL_W-1:0];
          bot_pages_d = alu_res[LVL_W-1:0];
          cnt_d       = cnt_m1;
          state_d     = S_EMIT0;
        end
      end
      S_F_POFF: begin
        alu_op = ALU_SUB;
        alu_a  = lvl_ext(hunk_i);
        alu_b  = lvl_ext(top_pages_q);
        res0_d = mk_res('0, STAT_OK, PG_DECOMMIT, alu_sat[OFF_W-1:0],
                        sb_q[LVL_W-1:0]);
        top_used_d  = sa_q[LVL_W-1:0];
        top_pages_d = sc_q[LVL_W-1:0];
        cnt_d       = cnt_m1;
        state_d     = S_EMIT0;
      end

      S_T_POFF: begin
        alu_op = ALU_SUB;
        alu_a  = lvl_ext(hunk_i);
        alu_b  = lvl_ext(top_pages_q);
        if (req_q.req_type == REQ_CLEAR_TEMP) begin
          if (top_pages_q != '0) begin
            res0_d = top_rel;
          end
        end else begin
          // Full clear: bottom release first, then top.
          if (bot_pages_q != '0) begin
            res0_d = mk_res('0, STAT_OK, PG_DECOMMIT, '0, bot_pages_q);
            if (top_pages_q != '0) begin
              res1_d = top_rel;
              two_d  = 1'b1;
            end
          end else if (top_pages_q != '0) begin
            res0_d = top_rel;
          end
          bot_used_d  = '0;
          bot_pages_d = '0;
          for (int i = 0; i < MK_NUM; i++) begin
            mark_d[i] = '0;
          end
        end
        top_used_d  = '0;
        top_pages_d = '0;
        cnt_d       = '0;
        state_d     = S_EMIT0;
      end

      S_M_BOT: begin
        alu_op = ALU_SUB;
        alu_a  = lvl_ext(bot_pages_q);
        alu_b  = lvl_ext(mark_q[MK_BOT_PAGES]);
        if ((mark_q[MK_BOT_PAGES] != '0) && !alu_flag) begin
          bot_pages_d = mark_q[MK_BOT_PAGES];
          bot_used_d  = mark_q[MK_BOT_USED];
        end
        if ((mark_q[MK_BOT_PAGES] != '0) && diff_pos) begin
          res0_d = mk_res('0, STAT_OK, PG_DECOMMIT, mark_q[MK_BOT_PAGES][OFF_W-1:0],
                          alu_res[LVL_W-1:0]);
          bres_d = 1'b1;
        end else begin
          bres_d = 1'b0;
        end
        state_d = S_M_TOP;
      end
      S_M_TOP: begin
        alu_op  = ALU_SUB;
        alu_a   = lvl_ext(top_pages_q);
        alu_b   = lvl_ext(mark_q[MK_TOP_PAGES]);
        sc_d    = alu_res;
        tcond_d = (mark_q[MK_TOP_PAGES] != '0) && !alu_flag;
        grow_d  = (mark_q[MK_TOP_PAGES] != '0) && diff_pos;
        state_d = S_M_TOFF;
      end
      S_M_TOFF: begin
        alu_op = ALU_SUB;
        alu_a  = lvl_ext(hunk_i);
        alu_b  = lvl_ext(top_pages_q);
        if (grow_q) begin
          if (bres_q) begin
            res1_d = mk_res('0, STAT_OK, PG_DECOMMIT, alu_sat[OFF_W-1:0],
                            sc_q[LVL_W-1:0]);
            two_d  = 1'b1;
          end else begin
            res0_d = mk_res('0, STAT_OK, PG_DECOMMIT, alu_sat[OFF_W-1:0],
                            sc_q[LVL_W-1:0]);
          end
        end
        if (tcond_q) begin
          top_pages_d = mark_q[MK_TOP_PAGES];
          top_used_d  = mark_q[MK_TOP_USED];
        end
        for (int i = 0; i < MK_NUM; i++) begin
          mark_d[i] = '0;
        end
        state_d = S_EMIT0;
      end

      S_EMIT0: begin
        ctrl_o.valid           = 1'b1;
        ctrl_o.res             = res0_q;
        ctrl_o.res.last_result = !two_q;
        if (res_ready_i) begin
          state_d = two_q ? S_EMIT1 : S_IDLE;
        end
      end
      S_EMIT1: begin
        ctrl_o.valid           = 1'b1;
        ctrl_o.res             = res1_q;
        ctrl_o.res.last_result = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Closing step of a successful allocation.
    if (fin) begin
      res0_d = mk_res(fin_blk, STAT_OK, grow_q ? PG_COMMIT : PG_NONE,
                      grow_q ? fin_poff : '0, grow_q ? sb_q[LVL_W-1:0] : '0);
      if (sel_top_q) begin
        top_pages_d = fin_pages;
        top_used_d  = sa_q[LVL_W-1:0];
      end else begin
        bot_pages_d = fin_pages;
        bot_used_d  = sa_q[LVL_W-1:0];
      end
      if (req_q.req_type == REQ_ALLOC_TEMP) begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + TEMP_CNT_W'(1);
      end
      state_d = S_EMIT0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tat_q       <= 1'b0;
      cnt_q       <= '0;
      bot_used_q  <= '0;
      bot_pages_q <= '0;
      top_used_q  <= '0;
      top_pages_q <= '0;
      for (int i = 0; i < MK_NUM; i++) begin
        mark_q[i] <= '0;
      end
      two_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      tat_q       <= tat_d;
      cnt_q       <= cnt_d;
      bot_used_q  <= bot_used_d;
      bot_pages_q <= bot_pages_d;
      top_used_q  <= top_used_d;
      top_pages_q <= top_pages_d;
      for (int i = 0; i < MK_NUM; i++) begin
        mark_q[i] <= mark_d[i];
      end
      two_q       <= two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    sel_top_q <= sel_top_d;
    grow_q    <= grow_d;
    bres_q    <= bres_d;
    tcond_q   <= tcond_d;
    sa_q      <= sa_d;
    sb_q      <= sb_d;
    sc_q      <= sc_d;
    res0_q    <= res0_d;
    res1_q    <= res1_d;
  end

endmodule
`default_nettype wire

[rtl/double_ended_hunk_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequencing: from acceptance a request keeps the controller busy, with one add or
// subtract through the shared adder per cycle (a top-end allocation that commits
// pages is the longest); each result is then registered in the result stage.
// Throughput: one request at a time; the next is accepted once all its results left.
// Reset: asynchronous, active low; levels, marks, bank flag and temporary count clear,
// the region size returns to 16 MiB; the temporary offset store is not cleared.
// ----------------------------------------------------------------------------
// double_ended_hunk_allocator: double-ended stack allocator, top level
// Region size register, request sequencer and a registered result stage.
// ----------------------------------------------------------------------------
module double_ended_hunk_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dhalloc_pkg::req_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dhalloc_pkg::res_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dhalloc_pkg::LVL_W-1:0]  cfg_data_i
);
  import dhalloc_pkg::*;

  logic [LVL_W-1:0] hunk_q;
  ctrl_out_t        ctrl;
  logic             res_ready;
  logic             out_valid_q;
  res_t             out_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunk_q <= HUNK_RESET;
    end else if (cfg_valid_i) begin
      hunk_q <= cfg_data_i;
    end
  end

  dhalloc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .hunk_i      (hunk_q),
    .res_ready_i (res_ready),
    .ctrl_o      (ctrl)
  );

  assign in_stall_o = !ctrl.idle;

  // The result stage takes a new transaction whenever it is empty or draining.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= ctrl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.valid && res_ready) begin
      out_data_q <= ctrl.res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("controller still idle after taking a request");

  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !ctrl.valid)
    else $error("result offered while the controller is idle");

  a_error_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.valid && ctrl.res.status != STAT_OK)
      |-> (ctrl.res.last_result && ctrl.res.page_op == PG_NONE))
    else $error("error result carries a page operation or is not final");

  a_no_op_zero_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.page_op == PG_NONE)
      |-> (out_data_o.page_offset == '0 && out_data_o.page_length == '0))
    else $error("page range set without a page operation");

endmodule
`default_nettype wire

[tb/sv/dhalloc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhalloc_checker: result checker for the double-ended hunk allocator
// Watches the request, result and region size channels, keeps its own copy
// of both stack ends, the marks and the temporary block stack, and compares
// every result transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module dhalloc_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  dhalloc_pkg::req_t              in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  dhalloc_pkg::res_t              out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [dhalloc_pkg::LVL_W-1:0]  cfg_data_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    due_count_o,
  output int unsigned                    checked_count_o,
  output int unsigned                    temp_live_o,
  output logic [dhalloc_pkg::OFF_W-1:0]  temp_latest_o
);
  import dhalloc_pkg::*;

  // Wide enough for both committed levels plus a page-rounded growth.
  typedef logic [31:0] sum_t;

  logic [LVL_W-1:0] region_bytes;
  logic [LVL_W-1:0] bot_used, bot_pages, top_used, top_pages;
  logic [LVL_W-1:0] marks [MK_NUM];
  logic             temps_on_top;
  logic [OFF_W-1:0] temp_offsets [TEMP_DEPTH];
  int unsigned      temp_live;
  res_t             due_replies [$];

  // Offset of a level counted down from the end of the region; a region that
  // has shrunk below the level gives zero.
  function automatic sum_t top_down(input sum_t level);
    return (level > sum_t'(region_bytes)) ? '0 : sum_t'(region_bytes) - level;
  endfunction

  task automatic push_reply(input sum_t blk, input status_e st, input page_op_e op,
                            input sum_t off, input sum_t len);
    res_t r;
    r.block_offset = blk[LVL_W-1:0];
    r.status       = st;
    r.page_op      = op;
    r.page_offset  = off[OFF_W-1:0];
    r.page_length  = len[LVL_W-1:0];
    r.last_result  = 1'b0;
    due_replies.push_back(r);
  endtask

  task automatic grow_end(input logic at_top, input sum_t size, output logic ok,
                          output logic [LVL_W-1:0] blk_out);
    sum_t u, p, need, extra, blk;
    u     = sum_t'(at_top ? top_used : bot_used);
    p     = sum_t'(at_top ? top_pages : bot_pages);
    need  = u + size;
    extra = '0;
    ok    = 1'b1;
    blk_out = '0;
    if (need > p) begin
      extra = ((need - p + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
      if (sum_t'(bot_pages) + sum_t'(top_pages) + extra > sum_t'(region_bytes)) begin
        push_reply('0, STAT_NO_ROOM, PG_NONE, '0, '0);
        ok = 1'b0;
        return;
      end
    end
    if (at_top) begin
      blk = top_down(need);
      if (extra != 0) push_reply(blk, STAT_OK, PG_COMMIT, top_down(p + extra), extra);
      else push_reply(blk, STAT_OK, PG_NONE, '0, '0);
    end else begin
      blk = u;
      if (extra != 0) push_reply(blk, STAT_OK, PG_COMMIT, p, extra);
      else push_reply(blk, STAT_OK, PG_NONE, '0, '0);
    end
    blk_out = blk[LVL_W-1:0];
    if (at_top) begin
      top_pages = LVL_W'(p + extra);
      top_used  = LVL_W'(need);
    end else begin
      bot_pages = LVL_W'(p + extra);
      bot_used  = LVL_W'(need);
    end
  endtask

  task automatic serve_request(input req_t q);
    sum_t             size, u, p, freed;
    logic             ok;
    logic [LVL_W-1:0] blk;
    int unsigned      queued;
    res_t             tail;
    size   = sum_t'(q.req_size);
    queued = due_replies.size();
    case (q.req_type)
      REQ_ALLOC: grow_end(!temps_on_top, size, ok, blk);
      REQ_ALLOC_TEMP: begin
        if (temp_live >= TEMP_DEPTH) begin
          push_reply('0, STAT_FULL, PG_NONE, '0, '0);
        end else begin
          grow_end(temps_on_top, size, ok, blk);
          if (ok) begin
            temp_offsets[temp_live] = blk[OFF_W-1:0];
            temp_live++;
          end
        end
      end
      REQ_FREE_TEMP: begin
        // Only the most recent temporary block may be released.
        if (temp_live == 0 || temp_offsets[temp_live-1] != q.req_offset) begin
          push_reply('0, STAT_REFUSED, PG_NONE, '0, '0);
        end else begin
          temp_live--;
          u     = sum_t'(temps_on_top ? top_used : bot_used);
          p     = sum_t'(temps_on_top ? top_pages : bot_pages);
          u     = (size > u) ? '0 : u - size;
          freed = (p > u) ? p - u : '0;
          freed = (freed / PAGE_BYTES) * PAGE_BYTES;
          if (freed != 0) begin
            push_reply('0, STAT_OK, PG_DECOMMIT, temps_on_top ? top_down(p) : p - freed,
                       freed);
            p = p - freed;
          end else begin
            push_reply('0, STAT_OK, PG_NONE, '0, '0);
          end
          if (temps_on_top) begin
            top_used  = LVL_W'(u);
            top_pages = LVL_W'(p);
          end else begin
            bot_used  = LVL_W'(u);
            bot_pages = LVL_W'(p);
          end
        end
      end
      REQ_CLEAR_TEMP: begin
        if (temps_on_top) begin
          if (top_pages != 0)
            push_reply('0, STAT_OK, PG_DECOMMIT, top_down(sum_t'(top_pages)),
                       sum_t'(top_pages));
          else
            push_reply('0, STAT_OK, PG_NONE, '0, '0);
          top_used  = '0;
          top_pages = '0;
        end else begin
          if (bot_pages != 0)
            push_reply('0, STAT_OK, PG_DECOMMIT, '0, sum_t'(bot_pages));
          else push_reply('0, STAT_OK, PG_NONE, '0, '0);
          bot_used  = '0;
          bot_pages = '0;
        end
        temp_live = 0;
      end
      REQ_SWAP: begin
        temps_on_top = !temps_on_top;
        push_reply('0, STAT_OK, PG_NONE, '0, '0);
      end
      REQ_CLEAR: begin
        if (bot_pages != 0) push_reply('0, STAT_OK, PG_DECOMMIT, '0, sum_t'(bot_pages));
        if (top_pages != 0)
          push_reply('0, STAT_OK, PG_DECOMMIT, top_down(sum_t'(top_pages)),
                     sum_t'(top_pages));
        bot_used  = '0;
        bot_pages = '0;
        top_used  = '0;
        top_pages = '0;
        foreach (marks[i]) marks[i] = '0;
        temp_live = 0;
      end
      REQ_SET_MARK: begin
        marks[MK_BOT_PAGES] = bot_pages;
        marks[MK_BOT_USED]  = bot_used;
        marks[MK_TOP_PAGES] = top_pages;
        marks[MK_TOP_USED]  = top_used;
        push_reply('0, STAT_OK, PG_NONE, '0, '0);
      end
      REQ_CLEAR_MARK: begin
        // An end is rolled back only when it has a mark and has not already
        // dropped below it.
        if (marks[MK_BOT_PAGES] != 0 && bot_pages >= marks[MK_BOT_PAGES]) begin
          if (bot_pages > marks[MK_BOT_PAGES])
            push_reply('0, STAT_OK, PG_DECOMMIT, sum_t'(marks[MK_BOT_PAGES]),
                       sum_t'(bot_pages) - sum_t'(marks[MK_BOT_PAGES]));
          bot_pages = marks[MK_BOT_PAGES];
          bot_used  = marks[MK_BOT_USED];
        end
        if (marks[MK_TOP_PAGES] != 0 && top_pages >= marks[MK_TOP_PAGES]) begin
          if (top_pages > marks[MK_TOP_PAGES])
            push_reply('0, STAT_OK, PG_DECOMMIT, top_down(sum_t'(top_pages)),
                       sum_t'(top_pages) - sum_t'(marks[MK_TOP_PAGES]));
          top_pages = marks[MK_TOP_PAGES];
          top_used  = marks[MK_TOP_USED];
        end
        foreach (marks[i]) marks[i] = '0;
      end
      default: push_reply('0, STAT_OK, PG_NONE, '0, '0);
    endcase
    if (due_replies.size() == queued) push_reply('0, STAT_OK, PG_NONE, '0, '0);
    tail = due_replies.pop_back();
    tail.last_result = 1'b1;
    due_replies.push_back(tail);
  endtask

  task automatic check_field(input string what, input sum_t want, input sum_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      region_bytes = HUNK_RESET;
      bot_used     = '0;
      bot_pages    = '0;
      top_used     = '0;
      top_pages    = '0;
      foreach (marks[i]) marks[i] = '0;
      temps_on_top = 1'b0;
      temp_live    = 0;
      due_replies.delete();
      fail_count_o    = 0;
      checked_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) region_bytes = cfg_data_i;
      if (in_valid_i && !in_stall_i) serve_request(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (due_replies.size() == 0) begin
          $display("%0t: result transaction with nothing expected, expected none, got 0x%h",
                   $time, out_data_i);
          fail_count_o++;
        end else begin
          want = due_replies.pop_front();
          checked_count_o++;
          check_field("block_offset", sum_t'(want.block_offset),
                      sum_t'(out_data_i.block_offset));
          check_field("status", sum_t'(want.status), sum_t'(out_data_i.status));
          check_field("page_op", sum_t'(want.page_op), sum_t'(out_data_i.page_op));
          check_field("page_offset", sum_t'(want.page_offset),
                      sum_t'(out_data_i.page_offset));
          check_field("page_length", sum_t'(want.page_length),
                      sum_t'(out_data_i.page_length));
          check_field("last_result", sum_t'(want.last_result),
                      sum_t'(out_data_i.last_result));
        end
      end
    end
    due_count_o   = due_replies.size();
    temp_live_o   = temp_live;
    temp_latest_o = (temp_live != 0) ? temp_offsets[temp_live-1] : '0;
  end

endmodule

[tb/sv/double_ended_hunk_allocator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_hunk_allocator_test: testbench for the double-ended allocator
// Drives a directed opening and then random request sequences over several
// region sizes and handshake patterns; the checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module double_ended_hunk_allocator_test;
  import dhalloc_pkg::*;

  localparam int unsigned ITEMS  = 950;
  localparam int unsigned ROUNDS = 8;
  localparam int unsigned SETTLE = 20;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  req_t             in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  res_t             out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LVL_W-1:0] cfg_data  = '0;

  int unsigned      chk_fails, chk_due, chk_checked, chk_temp_live;
  logic [OFF_W-1:0] chk_temp_latest;

  int unsigned      idle_pct  = 0;
  int unsigned      stall_pct = 0;
  int unsigned      sent      = 0;
  int unsigned      regions   = 0;

  always #5 clk = ~clk;

  double_ended_hunk_allocator u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  dhalloc_checker u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (chk_fails),
    .due_count_o     (chk_due),
    .checked_count_o (chk_checked),
    .temp_live_o     (chk_temp_live),
    .temp_latest_o   (chk_temp_latest)
  );

  always @(negedge clk) begin
    out_stall = rst_n && ($urandom_range(99) < stall_pct);
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Valid is left high after a transaction; the next call either replaces the
  // payload or lowers valid for an idle gap, so it changes once per step.
  task automatic send_request(input req_type_e kind, input logic [LVL_W-1:0] size,
                              input logic [OFF_W-1:0] offs);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{req_type: kind, req_size: size, req_offset: offs};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_region(input logic [LVL_W-1:0] bytes);
    in_valid = 1'b0;
    while (chk_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = bytes;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    regions++;
  endtask

  function automatic logic [LVL_W-1:0] pick_size();
    case ($urandom_range(19))
      0:          return LVL_W'($urandom);
      1, 2:       return LVL_W'($urandom_range(1 << 20));
      3, 4, 5, 6: return LVL_W'($urandom_range(65535));
      default:    return LVL_W'($urandom_range(8191));
    endcase
  endfunction

  function automatic logic [OFF_W-1:0] free_offset();
    if (chk_temp_live != 0 && $urandom_range(9) != 0) return chk_temp_latest;
    return OFF_W'($urandom);
  endfunction

  function automatic logic [LVL_W-1:0] region_for(input int unsigned r);
    case (r)
      0, 6:    return LVL_W'(1 << 26);
      1:       return LVL_W'(65536);
      2:       return '0;
      3:       return HUNK_RESET;
      4:       return LVL_W'($urandom_range(1, 1 << 26));
      5:       return LVL_W'($urandom_range(1, 16384) * PAGE_BYTES);
      default: return LVL_W'(1 << 20);
    endcase
  endfunction

  task automatic set_phase(input int unsigned ph);
    case (ph)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 61; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 61; end
      default: begin idle_pct = 7; stall_pct = 7; end
    endcase
  endtask

  // A mark, a run of allocations, some release requests (mostly for the newest
  // temporary block), then a roll-back, a temporary clear, a bank swap or none.
  task automatic send_frame();
    int unsigned n, m;
    n = $urandom_range(1, 8);
    m = $urandom_range(n);
    send_request(REQ_SET_MARK, pick_size(), OFF_W'($urandom));
    repeat (n)
      send_request($urandom_range(1) ? REQ_ALLOC_TEMP : REQ_ALLOC, pick_size(),
                   OFF_W'($urandom));
    repeat (m) send_request(REQ_FREE_TEMP, pick_size(), free_offset());
    case ($urandom_range(3))
      0: send_request(REQ_CLEAR_MARK, pick_size(), OFF_W'($urandom));
      1: send_request(REQ_CLEAR_TEMP, pick_size(), OFF_W'($urandom));
      2: send_request(REQ_SWAP, pick_size(), OFF_W'($urandom));
      default: ;
    endcase
  endtask

  initial begin
    int unsigned round_end;
    req_type_e   kind;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed opening at the reset region size.
    send_request(REQ_ALLOC, '0, '0);
    send_request(REQ_ALLOC, LVL_W'(5000), '1);
    send_request(REQ_ALLOC_TEMP, LVL_W'(1), '0);
    send_request(REQ_FREE_TEMP, LVL_W'(1), chk_temp_latest ^ OFF_W'(1));
    send_request(REQ_FREE_TEMP, LVL_W'(1), chk_temp_latest);
    send_request(REQ_FREE_TEMP, '0, '0);
    send_request(REQ_SET_MARK, '0, '0);
    send_request(REQ_ALLOC_TEMP, LVL_W'(100000), '0);
    send_request(REQ_ALLOC, LVL_W'(3000), '0);
    send_request(REQ_CLEAR_MARK, '0, '0);
    send_request(REQ_CLEAR_MARK, '1, '1);
    send_request(REQ_ALLOC, '1, '0);
    send_request(REQ_ALLOC_TEMP, LVL_W'(1 << 26), '0);
    send_request(REQ_SWAP, '0, '0);
    send_request(REQ_ALLOC_TEMP, LVL_W'(12288), '0);
    send_request(REQ_FREE_TEMP, '1, chk_temp_latest);
    send_request(REQ_ALLOC_TEMP, LVL_W'(20000), '0);
    send_request(REQ_SET_MARK, '0, '0);
    send_request(REQ_CLEAR_TEMP, '0, '0);
    send_request(REQ_CLEAR_MARK, '0, '0);
    send_request(REQ_ALLOC, LVL_W'(70000), '0);
    send_request(REQ_CLEAR, '0, '0);
    send_request(REQ_SWAP, '0, '0);

    for (int unsigned r = 0; r < ROUNDS; r++) begin
      write_region(region_for(r));
      set_phase(r % 4);
      round_end = sent + ITEMS / ROUNDS;
      // Some rounds fill the temporary stack close to or past its depth on purpose.
      if (r % 3 == 0) begin
        repeat ($urandom_range(30, 35))
          send_request(REQ_ALLOC_TEMP, LVL_W'($urandom_range(4096)), OFF_W'($urandom));
        send_request(REQ_FREE_TEMP, pick_size(), chk_temp_latest);
        send_request(REQ_CLEAR_TEMP, '0, '0);
      end
      while (sent < round_end) begin
        if ($urandom_range(9) < 7) begin
          send_frame();
        end else begin
          kind = req_type_e'($urandom_range(7));
          send_request(kind, pick_size(),
                       (kind == REQ_FREE_TEMP) ? free_offset() : OFF_W'($urandom));
        end
      end
    end

    in_valid = 1'b0;
    while (chk_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    $display("Ran %0d requests over %0d region sizes and four handshake patterns.",
             sent, regions + 1);
    $display("Compared %0d result transactions with the predicted allocator state.",
             chk_checked);
    if (chk_fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
